@@ design/fca_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants of the chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int BLOCK_BITS_DEF  = 16;

   localparam logic [15:0] DATA_START_RST = 16'd4;
   localparam logic [10:0] DATA_COUNT_RST = 11'd1024;

   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_LOCATE = 3'd2,
      OP_READ  = 3'd3,
      OP_WRITE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFREE  = 2'd1,
      ST_INVALID = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   localparam logic CSR_DATA_START = 1'b0;
   localparam logic CSR_DATA_COUNT = 1'b1;

endpackage
`default_nettype wire

@@ design/fca_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fca_table
// Link table memory, one port, registered read.
// ----------------------------------------------------------------------------
module fca_table
   import fca_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int BLOCK_BITS  = BLOCK_BITS_DEF,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [AW-1:0]         addr,
   input  wire logic [BLOCK_BITS-1:0] wdata,
   output logic      [BLOCK_BITS-1:0] rdata
);

   logic [BLOCK_BITS-1:0] mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
`default_nettype wire

@@ design/fat_chain_allocator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fat_chain_allocator_core
// File allocation table chain allocator: allocate, free chain, locate,
// raw entry read and write over one link table memory.
// ----------------------------------------------------------------------------
// After reset a clearing pass writes every table entry to free, one entry a
// cycle; busy stays high meanwhile. A request is taken when start is high
// and busy low; busy then stays high until the cycle of the single response,
// shown for one cycle with rsp_valid, and the next request can be taken in
// that cycle. All table accesses share one memory port with a registered
// read, so each entry looked at takes a read state and a check state. Write
// entry, unused opcodes and early errors go from dispatch straight to the
// done state, and read entry passes a read state first. Allocate scans at
// most the active block count of entries, free visits each link of the
// chain, and locate walks the chain link by link, scanning for a free entry
// and writing one link whenever the chain grows. The receiver cannot stall
// the response.
// ----------------------------------------------------------------------------
module fat_chain_allocator_core
   import fca_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [15:0] req_start_block,
   input  wire logic        req_has_start,
   input  wire logic [15:0] req_block_ordinal,
   input  wire logic        req_allocate_missing,
   input  wire logic [15:0] req_entry_in,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_block_out,
   output logic [15:0]      rsp_first_block_out,
   output logic             rsp_newly_allocated,
   output logic [15:0]      rsp_entry_out
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [BLOCK_BITS-1:0] EOC = '1;
   localparam logic [31:0] EOC32 = 32'(EOC);
   localparam logic [31:0] LIM = (EOC32 < 32'hFFFF) ? EOC32 : 32'hFFFF;

   typedef enum logic [10:0] {
      S_CLEAR   = 11'b00000000001,
      S_IDLE    = 11'b00000000010,
      S_DISP    = 11'b00000000100,
      S_A_RD    = 11'b00000001000,
      S_A_CHK   = 11'b00000010000,
      S_F_RD    = 11'b00000100000,
      S_F_CHK   = 11'b00001000000,
      S_L_RD    = 11'b00010000000,
      S_L_CHK   = 11'b00100000000,
      S_E_RD    = 11'b01000000000,
      S_DONE    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] dstart_ff;
   logic [10:0] dcount_ff;
   logic [31:0] hint_ff, hint_in;

   op_type      op_ff;
   logic [31:0] blk_ff, blk_in;        // current block
   logic [15:0] ord_ff, ord_in;
   logic        amiss_ff, has_ff;
   logic [15:0] ein_ff;
   logic [CW:0] k_ff, k_in;            // scan / step counter
   logic [CW-1:0] idx_ff, idx_in;      // scan index
   logic        inalloc_ff, inalloc_in; // locate waiting for an allocation
   logic        needfirst_ff, needfirst_in;

   logic [1:0]  st_ff, st_in;
   logic [15:0] bo_ff, bo_in, fo_ff, fo_in;
   logic        na_ff, na_in;

   logic [AW-1:0] clr_ff, clr_in;

   logic                  m_we;
   logic [AW-1:0]         m_addr;
   logic [BLOCK_BITS-1:0] m_wdata, m_rdata;

   fca_table #(.TABLE_DEPTH(TABLE_DEPTH), .BLOCK_BITS(BLOCK_BITS)) u_tbl (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
   );

   // active count
   logic [31:0] n_act;
   always_comb begin
      logic [31:0] n;
      n = 32'd0;
      if (32'(dstart_ff) < LIM) begin
         n = LIM - 32'(dstart_ff);
         if (32'(dcount_ff) < n) n = 32'(dcount_ff);
         if (32'(TABLE_DEPTH) < n) n = 32'(TABLE_DEPTH);
      end
      n_act = n;
   end

   function automatic logic is_data(input logic [31:0] b, input logic [15:0] ds,
                                    input logic [31:0] n);
      return (b >= 32'(ds)) && ((b - 32'(ds)) < n);
   endfunction

   logic [31:0] rel_blk;
   logic [31:0] rd32;
   logic        blk_ok, hint_ok, nx_ok;
   logic [31:0] idx_nxt;
   assign rel_blk = blk_ff - 32'(dstart_ff);
   assign rd32    = 32'(m_rdata);
   assign blk_ok  = is_data(blk_ff, dstart_ff, n_act);
   assign hint_ok = is_data(hint_ff, dstart_ff, n_act);
   assign nx_ok   = is_data(rd32, dstart_ff, n_act);
   assign idx_nxt = (32'(idx_ff) + 32'd1 >= n_act) ? 32'd0 : 32'(idx_ff) + 32'd1;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      hint_in  = hint_ff;
      blk_in   = blk_ff;
      ord_in   = ord_ff;
      k_in     = k_ff;
      idx_in   = idx_ff;
      inalloc_in = inalloc_ff;
      needfirst_in = needfirst_ff;
      st_in = st_ff; bo_in = bo_ff; fo_in = fo_ff; na_in = na_ff;
      clr_in  = clr_ff;
      m_we    = 1'b0;
      m_addr  = AW'(rel_blk);
      m_wdata = '0;

      case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1;
            m_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(TABLE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               blk_in = 32'(req_start_block);
               ord_in = req_block_ordinal;
               st_in = ST_OK; bo_in = '0; fo_in = '0; na_in = 1'b0;
               k_in = '0; inalloc_in = 1'b0; needfirst_in = 1'b0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_DONE;
            case (op_ff)
               OP_ALLOC: begin
                  inalloc_in = 1'b0;
                  if (n_act == 0) st_in = ST_NOFREE;
                  else begin
                     idx_in = hint_ok ? CW'(hint_ff - 32'(dstart_ff)) : '0;
                     k_in = '0;
                     state_in = S_A_RD;
                  end
               end
               OP_FREE: begin
                  if (has_ff) begin
                     k_in = '0;
                     if (!blk_ok) st_in = ST_INVALID;
                     else state_in = S_F_RD;
                  end
               end
               OP_LOCATE: begin
                  if (!has_ff) begin
                     if (!amiss_ff) st_in = ST_MISSING;
                     else if (n_act == 0) st_in = ST_NOFREE;
                     else begin
                        needfirst_in = 1'b1;
                        inalloc_in = 1'b1;
                        idx_in = hint_ok ? CW'(hint_ff - 32'(dstart_ff)) : '0;
                        k_in = '0;
                        state_in = S_A_RD;
                     end
                  end else begin
                     fo_in = blk_ff[15:0];
                     if (ord_ff == 0) bo_in = blk_ff[15:0];
                     else if (!blk_ok) st_in = ST_INVALID;
                     else state_in = S_L_RD;
                  end
               end
               OP_READ, OP_WRITE: begin
                  if (!blk_ok) st_in = ST_INVALID;
                  else if (op_ff == OP_WRITE) begin
                     m_we = 1'b1;
                     m_wdata = ein_ff[BLOCK_BITS-1:0] & EOC;
                  end else state_in = S_E_RD;
               end
               default: ;
            endcase
         end
         S_A_RD: begin
            m_addr = AW'(idx_ff);
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            m_addr = AW'(idx_ff);
            if (m_rdata == '0) begin
               m_we = 1'b1;
               m_wdata = EOC;
               hint_in = 32'(dstart_ff) + idx_nxt;
               if (!inalloc_ff) begin
                  bo_in = 16'(32'(dstart_ff) + 32'(idx_ff));
                  state_in = S_DONE;
               end else begin
                  na_in = 1'b1;
                  inalloc_in = 1'b0;
                  if (needfirst_ff) begin
                     needfirst_in = 1'b0;
                     blk_in = 32'(dstart_ff) + 32'(idx_ff);
                     fo_in = 16'(32'(dstart_ff) + 32'(idx_ff));
                     if (ord_ff == 0) begin
                        bo_in = 16'(32'(dstart_ff) + 32'(idx_ff));
                        state_in = S_DONE;
                     end else state_in = S_L_RD;
                  end else begin
                     // link previous block to the new one
                     state_in = S_L_CHK;
                     k_in = '1;
                     idx_in = idx_ff;
                  end
               end
            end else begin
               idx_in = CW'(idx_nxt);
               k_in = k_ff + 1'b1;
               if (32'(k_ff) + 32'd1 >= n_act) begin
                  st_in = ST_NOFREE;
                  state_in = S_DONE;
               end else state_in = S_A_RD;
            end
         end
         S_F_RD: begin
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            m_we = 1'b1;
            m_wdata = '0;
            if (blk_ff < hint_ff || !hint_ok) hint_in = blk_ff;
            state_in = S_DONE;
            if (m_rdata != EOC && m_rdata != '0 && 32'(k_ff) + 32'd1 <= n_act) begin
               blk_in = rd32;
               k_in = k_ff + 1'b1;
               if (!nx_ok) st_in = ST_INVALID;
               else state_in = S_F_RD;
            end
         end
         S_L_RD: begin
            state_in = S_L_CHK;
            k_in = '0;
         end
         S_L_CHK: begin
            if (k_ff != '0) begin
               // write link after allocation, idx_ff holds new block
               m_we = 1'b1;
               m_wdata = BLOCK_BITS'(32'(dstart_ff) + 32'(idx_ff));
               blk_in = 32'(dstart_ff) + 32'(idx_ff);
               ord_in = ord_ff - 1'b1;
               k_in = '0;
               if (ord_ff == 16'd1) begin
                  bo_in = 16'(32'(dstart_ff) + 32'(idx_ff));
                  state_in = S_DONE;
               end else state_in = S_L_RD;
            end else if (m_rdata == EOC) begin
               if (!amiss_ff) begin
                  st_in = ST_MISSING; state_in = S_DONE;
               end else begin
                  inalloc_in = 1'b1;
                  idx_in = hint_ok ? CW'(hint_ff - 32'(dstart_ff)) : '0;
                  k_in = '0;
                  state_in = S_A_RD;
               end
            end else if (!nx_ok) begin
               st_in = ST_INVALID; state_in = S_DONE;
            end else begin
               blk_in = rd32;
               ord_in = ord_ff - 1'b1;
               if (ord_ff == 16'd1) begin
                  bo_in = m_rdata[15:0];
                  state_in = S_DONE;
               end else state_in = S_L_RD;
            end
         end
         S_E_RD: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // S_E_RD reads; S_DONE captures. Ensure address held for read op.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         dstart_ff <= DATA_START_RST;
         dcount_ff <= DATA_COUNT_RST;
         hint_ff <= 32'(DATA_START_RST);
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         hint_ff <= hint_in;
         if (csr_write) begin
            if (csr_index == CSR_DATA_START) dstart_ff <= csr_data;
            else dcount_ff <= csr_data[10:0];
         end
         rsp_valid <= (state_ff == S_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff <= op_type'(req_opcode);
         has_ff <= req_has_start;
         amiss_ff <= req_allocate_missing;
         ein_ff <= req_entry_in;
      end
      blk_ff <= blk_in; ord_ff <= ord_in; k_ff <= k_in; idx_ff <= idx_in;
      inalloc_ff <= inalloc_in; needfirst_ff <= needfirst_in;
      st_ff <= st_in; bo_ff <= bo_in; fo_ff <= fo_in; na_ff <= na_in;
      if (state_ff == S_DONE) begin
         rsp_status <= st_ff;
         rsp_block_out <= bo_ff;
         rsp_first_block_out <= fo_ff;
         rsp_newly_allocated <= na_ff;
         rsp_entry_out <= (op_ff == OP_READ && st_ff == ST_OK) ? m_rdata[15:0] : 16'd0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid));
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid)
      else $error("response not issued");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy during response");

endmodule
`default_nettype wire
